FILE: rtl/mciir_pkg.sv
// Shared types and constants for the multichannel IIR filter.
// No dependencies; every other file imports this package.
`default_nettype none

package mciir_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 18;
    localparam int FRAC_BITS      = 16;
    localparam int CHAN_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic [CHAN_BITS-1:0]          chan_t;
    typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;

    // Coefficient register indexes
    localparam cfg_index_t REG_B0 = 3'd0;
    localparam cfg_index_t REG_B1 = 3'd1;
    localparam cfg_index_t REG_B2 = 3'd2;
    localparam cfg_index_t REG_A1 = 3'd3;
    localparam cfg_index_t REG_A2 = 3'd4;

    // Reset values, Q2.16
    localparam coef_t B0_RESET = 18'sd65536;
    localparam coef_t COEF_ZERO = 18'sd0;

    // func field codes
    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

endpackage

`default_nettype wire

FILE: rtl/mciir_in_if.sv
// Input channel of the multichannel IIR filter: valid/ready plus one item.
// Depends on mciir_pkg.
`default_nettype none

interface mciir_in_if;
    import mciir_pkg::*;

    logic    valid;
    logic    ready;
    logic    func;
    chan_t   channel;
    sample_t sample;

    modport source (output valid, output func, output channel, output sample,
                    input ready);
    modport sink   (input valid, input func, input channel, input sample,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/mciir_out_if.sv
// Result channel of the multichannel IIR filter: valid/ready plus one result.
// Depends on mciir_pkg.
`default_nettype none

interface mciir_out_if;
    import mciir_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filtered;
    chan_t   out_channel;

    modport source (output valid, output filtered, output out_channel, input ready);
    modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface

`default_nettype wire

FILE: rtl/mciir_coef_regs.sv
// Coefficient register file, written through the plain config write port.
// Depends on mciir_pkg.
`default_nettype none

module mciir_coef_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire mciir_pkg::cfg_index_t cfg_index,
    input  wire mciir_pkg::coef_t      cfg_data,
    output mciir_pkg::coef_set_t       coefs
);
    import mciir_pkg::*;

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_B0:  coefs_next.b0 = cfg_data;
                REG_B1:  coefs_next.b1 = cfg_data;
                REG_B2:  coefs_next.b2 = cfg_data;
                REG_A1:  coefs_next.a1 = cfg_data;
                REG_A2:  coefs_next.a2 = cfg_data;
                default: coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0 <= B0_RESET;
            coefs_reg.b1 <= COEF_ZERO;
            coefs_reg.b2 <= COEF_ZERO;
            coefs_reg.a1 <= COEF_ZERO;
            coefs_reg.a2 <= COEF_ZERO;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

`default_nettype wire

FILE: rtl/mciir_mac.sv
// Filter arithmetic: five products, sum, round to nearest (halves up), saturate.
// Purely combinational. Depends on mciir_pkg.
`default_nettype none

module mciir_mac #(
    parameter int ORDER = 2
) (
    input  wire mciir_pkg::coef_set_t coefs,
    input  wire mciir_pkg::sample_t   x0,
    input  wire mciir_pkg::sample_t   x1,
    input  wire mciir_pkg::sample_t   x2,
    input  wire mciir_pkg::sample_t   y1,
    input  wire mciir_pkg::sample_t   y2,
    output mciir_pkg::sample_t        y
);
    import mciir_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int RND_W  = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-(1 <<< (SAMPLE_BITS - 1)));

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [RND_W-1:0]  rnd;

    assign p_b0 = PROD_W'(coefs.b0) * PROD_W'(x0);
    assign p_b1 = PROD_W'(coefs.b1) * PROD_W'(x1);
    assign p_a1 = PROD_W'(coefs.a1) * PROD_W'(y1);

    generate
        if (ORDER >= 2)
        begin : g_second
            assign p_b2 = PROD_W'(coefs.b2) * PROD_W'(x2);
            assign p_a2 = PROD_W'(coefs.a2) * PROD_W'(y2);
        end
        else
        begin : g_first
            assign p_b2 = '0;
            assign p_a2 = '0;
        end
    endgenerate

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2);

    // floor((acc + 0.5) ) in Q16
    assign acc_rnd = acc + HALF;
    assign rnd     = acc_rnd[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        if (rnd > SAT_HI)
            y = SAT_HI[SAMPLE_BITS-1:0];
        else if (rnd < SAT_LO)
            y = SAT_LO[SAMPLE_BITS-1:0];
        else
            y = rnd[SAMPLE_BITS-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/multichannel_iir_filter.sv
// Multichannel direct-form-I IIR filter, order up to two, shared coefficients.
// Depends on mciir_pkg, mciir_in_if, mciir_out_if, mciir_coef_regs, mciir_mac.
//
// Usage:
//   din  carries transactions {func, channel, sample}. func filter computes
//        y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 for that channel and
//        returns one result on dout; func clear forgets every channel's
//        history and returns nothing. Filter items for channels at or
//        above CHANNELS are dropped without effect.
//   dout carries {filtered, out_channel}.
//   cfg_we/cfg_index/cfg_data write the five Q2.16 coefficients; write
//        only while no transaction is in flight.
// Path: an accepted transaction is held in the input register, then
//   loaded into the result register, which drives dout.
// Throughput: one transaction per cycle while dout is free, any channel
//   order, including the same channel back to back; the channel history is
//   updated together with the result register, so the next item sees it.
// Reset: coefficients return to b0 = 1.0 and zeros elsewhere; all channels
//   unprimed, so each channel's first sample fills its history with itself.
// Stall: when dout is held, the result stays and one more transaction is
//   taken into the input register; din.ready then drops until dout moves.
`default_nettype none

module multichannel_iir_filter #(
    parameter int CHANNELS = 4,
    parameter int ORDER    = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mciir_in_if.sink                   din,
    mciir_out_if.source                dout,
    input  wire logic                  cfg_we,
    input  wire mciir_pkg::cfg_index_t cfg_index,
    input  wire mciir_pkg::coef_t      cfg_data
);
    import mciir_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW    = (IDX_W > CHAN_BITS) ? IDX_W : CHAN_BITS;

    coef_set_t coefs;

    // input register
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_func_reg;
    chan_t   s1_channel_reg;
    sample_t s1_sample_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    sample_t out_filtered_reg;
    chan_t   out_channel_reg;

    // per-channel history
    sample_t               x1_reg [CHANNELS];
    sample_t               x2_reg [CHANNELS];
    sample_t               y1_reg [CHANNELS];
    sample_t               y2_reg [CHANNELS];
    logic [CHANNELS-1:0]   primed_reg, primed_next;

    logic             load_s1;
    logic             advance;
    logic             is_sample;
    logic [CW-1:0]    ch_wide;
    logic [IDX_W-1:0] ch_idx;
    logic             ch_ok;
    logic             fresh;
    sample_t          hx1, hx2, hy1, hy2;
    sample_t          y;

    mciir_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    assign ch_wide   = CW'(s1_channel_reg);
    assign ch_idx    = ch_wide[IDX_W-1:0];
    // one extra bit so a power-of-two channel count does not wrap to zero
    assign ch_ok     = ({1'b0, ch_wide} < (CW+1)'(CHANNELS));
    assign is_sample = (s1_func_reg == FUNC_FILTER) && ch_ok;

    assign advance  = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || advance;
    assign load_s1  = din.valid && din.ready;

    // unprimed channel: history reads as the current sample
    assign fresh = !primed_reg[ch_idx];
    assign hx1   = fresh ? s1_sample_reg : x1_reg[ch_idx];
    assign hx2   = fresh ? s1_sample_reg : x2_reg[ch_idx];
    assign hy1   = fresh ? s1_sample_reg : y1_reg[ch_idx];
    assign hy2   = fresh ? s1_sample_reg : y2_reg[ch_idx];

    mciir_mac #(
        .ORDER (ORDER)
    ) u_mac (
        .coefs (coefs),
        .x0    (s1_sample_reg),
        .x1    (hx1),
        .x2    (hx2),
        .y1    (hy1),
        .y2    (hy2),
        .y     (y)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load_s1)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = is_sample;
        else if (dout.ready)
            out_valid_next = 1'b0;

        primed_next = primed_reg;
        if (advance && s1_func_reg == FUNC_CLEAR)
            primed_next = '0;
        else if (advance && is_sample)
            primed_next[ch_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            primed_reg    <= primed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_func_reg    <= din.func;
            s1_channel_reg <= din.channel;
            s1_sample_reg  <= din.sample;
        end
        if (advance && is_sample)
        begin
            out_filtered_reg <= y;
            out_channel_reg  <= s1_channel_reg;
            x2_reg[ch_idx]   <= hx1;
            x1_reg[ch_idx]   <= s1_sample_reg;
            y2_reg[ch_idx]   <= hy1;
            y1_reg[ch_idx]   <= y;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.filtered    = out_filtered_reg;
    assign dout.out_channel = out_channel_reg;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for multichannel_iir_filter: directed and random sample streams
// are scored against an in-bench direct-form-I predictor, with random stalls on both sides.
// Depends on mciir_pkg, mciir_in_if, mciir_out_if and the filter RTL.
`default_nettype none

module testbench;
    import mciir_pkg::*;

    localparam int CHANNELS       = 4;
    localparam int IDLE_PCT       = 13;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 10;
    localparam int PHASE_ITEMS    = 120;
    localparam int CLEAR_PCT      = 3;

    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;

    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;
    localparam coef_t   COEF_MAX   = 18'sh1FFFF;
    localparam coef_t   COEF_MIN   = 18'sh20000;

    typedef struct packed {
        sample_t filtered;
        chan_t   ch;
    } filter_out_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    cfg_index_t cfg_index;
    coef_t      cfg_data;

    mciir_in_if  din_if ();
    mciir_out_if dout_if ();

    multichannel_iir_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_if),
        .dout      (dout_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor state
    coef_set_t   coefs;
    longint      x_hist1 [CHANNELS];
    longint      x_hist2 [CHANNELS];
    longint      y_hist1 [CHANNELS];
    longint      y_hist2 [CHANNELS];
    bit          primed  [CHANNELS];
    filter_out_t pending_outputs [$];

    int error_count = 0;
    int idle_watch  = 0;
    bit burst_mode  = 1'b0;

    function automatic void clear_histories();
        for (int c = 0; c < CHANNELS; c++)
        begin
            x_hist1[c] = 0;
            x_hist2[c] = 0;
            y_hist1[c] = 0;
            y_hist2[c] = 0;
            primed[c]  = 1'b0;
        end
    endfunction

    function automatic sample_t filter_step(chan_t ch, sample_t x);
        longint xs;
        longint acc;
        longint y;
        xs = x;
        if (!primed[ch])
        begin
            x_hist1[ch] = xs;
            x_hist2[ch] = xs;
            y_hist1[ch] = xs;
            y_hist2[ch] = xs;
            primed[ch]  = 1'b1;
        end
        acc = longint'(signed'(coefs.b0)) * xs
            + longint'(signed'(coefs.b1)) * x_hist1[ch]
            + longint'(signed'(coefs.b2)) * x_hist2[ch]
            - longint'(signed'(coefs.a1)) * y_hist1[ch]
            - longint'(signed'(coefs.a2)) * y_hist2[ch];
        // round half up, then clamp to 24 bits
        y = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > OUT_MAX)
            y = OUT_MAX;
        else if (y < OUT_MIN)
            y = OUT_MIN;
        x_hist2[ch] = x_hist1[ch];
        x_hist1[ch] = xs;
        y_hist2[ch] = y_hist1[ch];
        y_hist1[ch] = y;
        return sample_t'(y);
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2, 3: return sample_t'(int'($urandom_range(1023)) - 512);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_set_t random_coefs(bit gentle);
        coef_set_t c;
        coef_t     v [5];
        for (int i = 0; i < 5; i++)
            v[i] = gentle ? coef_t'(int'($urandom_range(32767)) - 16384) : coef_t'($urandom);
        c = '{v[0], v[1], v[2], v[3], v[4]};
        return c;
    endfunction

    // Drive one transaction and update the prediction once it is taken.
    task automatic send_item(logic f, chan_t ch, sample_t x);
        filter_out_t res;
        while (!burst_mode && $urandom_range(99) < IDLE_PCT)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.func    <= f;
        din_if.channel <= ch;
        din_if.sample  <= x;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        if (f == FUNC_CLEAR)
            clear_histories();
        else
        begin
            res.filtered = filter_step(ch, x);
            res.ch       = ch;
            pending_outputs.push_back(res);
        end
    endtask

    task automatic send_random_item();
        if ($urandom_range(99) < CLEAR_PCT)
            send_item(FUNC_CLEAR, chan_t'($urandom), sample_t'($urandom));
        else
            send_item(FUNC_FILTER, chan_t'($urandom), random_sample());
    endtask

    task automatic drain();
        din_if.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        // a trailing clear leaves nothing to wait for, so give the pipe time to empty
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_coefs(coef_set_t c);
        cfg_index_t idx [5];
        coef_t      val [5];
        idx = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
        val = '{c.b0, c.b1, c.b2, c.a1, c.a2};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        // unused index: must leave every coefficient alone
        cfg_index <= cfg_index_t'($urandom_range(int'(REG_A2) + 1, (1 << CFG_INDEX_BITS) - 1));
        cfg_data  <= coef_t'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        coefs = c;
    endtask

    // Result scoring, output back-pressure and watchdog
    always @(posedge clk)
    begin : score_outputs
        filter_out_t want;
        dout_if.ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (pending_outputs.size() == 0)
                log_error($sformatf("unexpected result ch %0d value %0d",
                                    dout_if.out_channel, dout_if.filtered));
            else
            begin
                want = pending_outputs.pop_front();
                if (dout_if.filtered !== want.filtered || dout_if.out_channel !== want.ch)
                    log_error($sformatf("ch %0d value %0d, expected ch %0d value %0d",
                                        dout_if.out_channel, dout_if.filtered,
                                        want.ch, want.filtered));
            end
        end
        if (!rst_n || cfg_we || (din_if.valid && din_if.ready) ||
            (dout_if.valid && dout_if.ready))
            idle_watch = 0;
        else
        begin
            idle_watch++;
            if (idle_watch >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: watchdog, no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Reset coefficients give b0 = 1.0, so output follows input.
    task automatic test_reset_coefs();
        send_item(FUNC_FILTER, 2'd0, SAMPLE_MAX);
        send_item(FUNC_FILTER, 2'd1, SAMPLE_MIN);
        send_item(FUNC_FILTER, 2'd2, sample_t'(0));
        send_item(FUNC_FILTER, 2'd3, sample_t'(-1));
        send_item(FUNC_FILTER, 2'd0, sample_t'(12345));
        send_item(FUNC_FILTER, 2'd0, SAMPLE_MIN);
        drain();
    endtask

    // b0 of one LSB exposes the half-up rounding.
    task automatic test_rounding();
        set_coefs('{coef_t'(1), COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
        send_item(FUNC_FILTER, 2'd1, sample_t'(32768));
        send_item(FUNC_FILTER, 2'd1, sample_t'(-32768));
        send_item(FUNC_FILTER, 2'd2, sample_t'(-32769));
        send_item(FUNC_FILTER, 2'd3, sample_t'(98304));
        drain();
    endtask

    task automatic test_coef_extremes();
        set_coefs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN});
        send_item(FUNC_FILTER, 2'd0, SAMPLE_MAX);
        send_item(FUNC_FILTER, 2'd0, SAMPLE_MIN);
        send_item(FUNC_FILTER, 2'd3, SAMPLE_MIN);
        drain();
        set_coefs('{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX});
        send_item(FUNC_FILTER, 2'd0, SAMPLE_MAX);
        send_item(FUNC_FILTER, 2'd2, SAMPLE_MAX);
        send_item(FUNC_FILTER, 2'd2, SAMPLE_MIN);
        drain();
    endtask

    // Clear forgets all channels; the next sample of each channel primes again.
    task automatic test_clear();
        set_coefs('{coef_t'(16384), coef_t'(16384), coef_t'(16384),
                    coef_t'(-32768), coef_t'(8192)});
        send_item(FUNC_FILTER, 2'd1, sample_t'(1000));
        send_item(FUNC_CLEAR,  2'd3, SAMPLE_MAX);
        send_item(FUNC_FILTER, 2'd1, SAMPLE_MIN);
        send_item(FUNC_FILTER, 2'd1, sample_t'(5));
        send_item(FUNC_CLEAR,  2'd0, sample_t'(0));
        drain();
    endtask

    task automatic test_random_phases();
        coef_set_t c;
        for (int p = 0; p < 4; p++)
        begin
            c = random_coefs(p != 1);
            if (p == 2)
            begin
                // first-order filter
                c.b2 = COEF_ZERO;
                c.a2 = COEF_ZERO;
            end
            set_coefs(c);
            repeat (PHASE_ITEMS) send_random_item();
            drain();
        end
    endtask

    task automatic test_back_to_back();
        burst_mode = 1'b1;
        set_coefs(random_coefs(1'b1));
        repeat (PHASE_ITEMS) send_random_item();
        drain();
        burst_mode = 1'b0;
    endtask

    initial
    begin
        din_if.valid   = 1'b0;
        din_if.func    = FUNC_FILTER;
        din_if.channel = '0;
        din_if.sample  = '0;
        dout_if.ready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_B0;
        cfg_data       = COEF_ZERO;
        coefs          = '{B0_RESET, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
        clear_histories();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_rounding();
        test_coef_extremes();
        test_clear();
        test_random_phases();
        test_back_to_back();

        drain();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/mciir_pkg.sv
rtl/mciir_in_if.sv
rtl/mciir_out_if.sv
rtl/mciir_coef_regs.sv
rtl/mciir_mac.sv
rtl/multichannel_iir_filter.sv
tb/testbench.sv
